[rtl/sound_register_write_logger_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef SOUND_REGISTER_WRITE_LOGGER_TOP_DEFINES_SVH
`define SOUND_REGISTER_WRITE_LOGGER_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SWL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SWL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/swl_pkg.sv]
package swl_pkg;

    // Input item kinds
    localparam logic [1:0] CMD_IO   = 2'd0;
    localparam logic [1:0] CMD_MEM  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_END  = 2'd3;

    // Stream opcodes
    localparam logic [7:0] OP_WAIT   = 8'h61;
    localparam logic [7:0] OP_END    = 8'h66;
    localparam logic [7:0] OP_FM     = 8'h51;
    localparam logic [7:0] OP_OPL    = 8'h5C;
    localparam logic [7:0] OP_PSG    = 8'hA0;
    localparam logic [7:0] OP_TONE   = 8'h50;
    localparam logic [7:0] OP_STEREO = 8'h4F;
    localparam logic [7:0] OP_WAVE   = 8'hD2;

    // One-time wave enable command payload
    localparam logic [7:0] WAVE_EN_DATA = 8'h1F;

    // Wave chip port codes
    localparam logic [7:0] WP_TABLE = 8'd0;
    localparam logic [7:0] WP_FREQ  = 8'd1;
    localparam logic [7:0] WP_VOL   = 8'd2;
    localparam logic [7:0] WP_EN    = 8'd3;
    localparam logic [7:0] WP_PTAB  = 8'd4;
    localparam logic [7:0] WP_SHARE = 8'd5;

    // I/O ports
    localparam logic [15:0] IO_FM_ADR0 = 16'h007C;
    localparam logic [15:0] IO_FM_ADR1 = 16'h00F0;
    localparam logic [15:0] IO_FM_DAT0 = 16'h007D;
    localparam logic [15:0] IO_FM_DAT1 = 16'h00F1;
    localparam logic [15:0] IO_OPL_ADR = 16'h00C0;
    localparam logic [15:0] IO_OPL_DAT = 16'h00C1;
    localparam logic [15:0] IO_PSG_ADR = 16'h00A0;
    localparam logic [15:0] IO_PSG_DAT = 16'h00A1;
    localparam logic [15:0] IO_TONE0   = 16'h007E;
    localparam logic [15:0] IO_TONE1   = 16'h007F;
    localparam logic [15:0] IO_STEREO  = 16'h0006;

    localparam logic [7:0] OPL_ADPCM_REG = 8'h0F;

    // Memory windows (upper address byte)
    localparam logic [7:0] WAVE_BASE  = 8'h98;
    localparam logic [7:0] WPLUS_BASE = 8'hB8;

    localparam logic [15:0] WAIT_MAX = 16'hFFFF;

    // Chip-use flag bits
    localparam int F_FM    = 0;
    localparam int F_OPL   = 1;
    localparam int F_ADPCM = 2;
    localparam int F_PSG   = 3;
    localparam int F_TONE  = 4;
    localparam int F_WAVE  = 5;
    localparam int F_WPLUS = 6;

    // Most bytes one item can produce: wait, enable, wave command
    localparam int MAX_BYTES = 11;

    // Classified command passed from front to back
    typedef struct packed {
        logic            has_wait;
        logic [15:0]     wait_val;
        logic            has_en;
        logic [2:0]      body_len;
        logic [3:0][7:0] body;
        logic [6:0]      flags;
    } t_cmd;

endpackage

[rtl/swl_front.sv]
module swl_front
    import swl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_full,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0] r_pend, n_pend;
    logic [7:0]  r_fm, n_fm;
    logic [7:0]  r_opl, n_opl;
    logic [7:0]  r_psg, n_psg;
    logic        r_init, n_init;
    logic [6:0]  r_flags, n_flags;

    logic        accept;
    logic        wen;
    logic        ovf;
    logic [7:0]  wport;
    logic [7:0]  woff;
    logic [7:0]  a;
    logic [2:0]  blen;
    logic [3:0][7:0] body;
    logic        has_en;

    assign accept = i_valid && !i_full;
    assign a      = i_addr[7:0];

    // Classify the item and work out the next state
    always_comb begin
        n_pend  = r_pend;
        n_fm    = r_fm;
        n_opl   = r_opl;
        n_psg   = r_psg;
        n_init  = r_init;
        n_flags = r_flags;
        wen     = 1'b0;
        ovf     = 1'b0;
        wport   = WP_TABLE;
        woff    = 8'd0;
        blen    = 3'd0;
        body    = '0;
        has_en  = 1'b0;

        unique case (i_cmd)
            CMD_IO: begin
                unique case (i_addr) inside
                    IO_FM_ADR0, IO_FM_ADR1: begin
                        n_flags[F_FM] = 1'b1;
                        n_fm = i_wdata;
                    end
                    IO_FM_DAT0, IO_FM_DAT1: begin
                        blen = 3'd3;
                        body = {8'd0, i_wdata, r_fm, OP_FM};
                    end
                    IO_OPL_ADR: begin
                        n_flags[F_OPL] = 1'b1;
                        n_opl = i_wdata;
                        if (i_wdata == OPL_ADPCM_REG) n_flags[F_ADPCM] = 1'b1;
                    end
                    IO_OPL_DAT: begin
                        blen = 3'd3;
                        body = {8'd0, i_wdata, r_opl, OP_OPL};
                    end
                    IO_PSG_ADR: begin
                        n_flags[F_PSG] = 1'b1;
                        n_psg = i_wdata;
                    end
                    IO_PSG_DAT: begin
                        blen = 3'd3;
                        body = {8'd0, i_wdata, r_psg, OP_PSG};
                    end
                    IO_TONE0, IO_TONE1: begin
                        n_flags[F_TONE] = 1'b1;
                        blen = 3'd2;
                        body = {16'd0, i_wdata, OP_TONE};
                    end
                    IO_STEREO: begin
                        blen = 3'd2;
                        body = {16'd0, i_wdata, OP_STEREO};
                    end
                    default: begin
                    end
                endcase
            end
            CMD_MEM: begin
                // First window: table, freq, volume, enable, mirrors, shared table
                if (i_addr[15:8] == WAVE_BASE) begin
                    wen = 1'b1;
                    if (a <= 8'h7F) begin
                        wport = WP_TABLE; woff = a;
                    end else if (a <= 8'h89) begin
                        wport = WP_FREQ; woff = a - 8'h80;
                        if (i_wdata != 8'd0) n_flags[F_WAVE] = 1'b1;
                    end else if (a <= 8'h8E) begin
                        wport = WP_VOL; woff = a - 8'h8A;
                    end else if (a == 8'h8F) begin
                        wport = WP_EN; woff = 8'd0;
                    end else if (a <= 8'h99) begin
                        wport = WP_FREQ; woff = a - 8'h90;
                        if (i_wdata != 8'd0) n_flags[F_WAVE] = 1'b1;
                    end else if (a <= 8'h9E) begin
                        wport = WP_VOL; woff = a - 8'h9A;
                    end else if (a == 8'h9F) begin
                        wport = WP_EN; woff = 8'd0;
                    end else if (a <= 8'hDF) begin
                        wen = 1'b0;
                    end else begin
                        wport = WP_SHARE; woff = a - 8'hE0;
                    end
                // Second window
                end else if (i_addr[15:8] == WPLUS_BASE) begin
                    wen = 1'b1;
                    if (a <= 8'h7F) begin
                        wport = WP_TABLE; woff = a;
                    end else if (a <= 8'h9F) begin
                        wport = WP_PTAB; woff = a;
                    end else if (a <= 8'hA9) begin
                        wport = WP_FREQ; woff = a - 8'hA0;
                        if (i_wdata != 8'd0) n_flags[F_WPLUS] = 1'b1;
                    end else if (a <= 8'hAE) begin
                        wport = WP_VOL; woff = a - 8'hAA;
                    end else if (a == 8'hAF) begin
                        wport = WP_EN; woff = 8'd0;
                    end else if (a <= 8'hB9) begin
                        wport = WP_FREQ; woff = a - 8'hB0;
                        if (i_wdata != 8'd0) n_flags[F_WPLUS] = 1'b1;
                    end else if (a <= 8'hBE) begin
                        wport = WP_VOL; woff = a - 8'hBA;
                    end else if (a == 8'hBF) begin
                        wport = WP_EN; woff = 8'd0;
                    end else if (a <= 8'hDF) begin
                        wport = WP_SHARE; woff = a - 8'hC0;
                    end else begin
                        wen = 1'b0;
                    end
                end
            end
            CMD_TICK: begin
                // full wait goes out at once on overflow
                if (r_pend == WAIT_MAX) begin
                    ovf = 1'b1;
                    n_pend = 16'd1;
                end else begin
                    n_pend = r_pend + 16'd1;
                end
            end
            CMD_END: begin
                blen = 3'd1;
                body = {24'd0, OP_END};
            end
            default: begin
            end
        endcase

        // wave command, preceded once by the enable command
        if (wen) begin
            blen   = 3'd4;
            body   = {i_wdata, woff, wport, OP_WAVE};
            has_en = !r_init;
            n_init = 1'b1;
        end

        // pending wait is flushed ahead of any command
        if (blen != 3'd0) n_pend = 16'd0;

        o_cmd.has_wait = ovf || ((blen != 3'd0) && (r_pend != 16'd0));
        o_cmd.wait_val = ovf ? WAIT_MAX : r_pend;
        o_cmd.has_en   = has_en;
        o_cmd.body_len = blen;
        o_cmd.body     = body;
        o_cmd.flags    = n_flags;
    end

    assign o_push = accept && (o_cmd.has_wait || (blen != 3'd0));

    // State update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_fm    <= '0;
            r_opl   <= '0;
            r_psg   <= '0;
            r_init  <= 1'b0;
            r_flags <= '0;
        end else if (accept) begin
            r_pend  <= n_pend;
            r_fm    <= n_fm;
            r_opl   <= n_opl;
            r_psg   <= n_psg;
            r_init  <= n_init;
            r_flags <= n_flags;
        end
    end

endmodule

[rtl/swl_queue.sv]
module swl_queue
    import swl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_nempty,
    output t_cmd o_cmd
);

    // two-entry queue between front and back
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full   = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_cmd    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

[rtl/swl_back.sv]
module swl_back
    import swl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_nempty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte,
    output logic [6:0] o_chips_seen
);

    logic [7:0] r_sh [MAX_BYTES];
    logic [7:0] a_sh [MAX_BYTES];
    logic [3:0] r_cnt;
    logic [3:0] a_cnt;
    logic [3:0] base;
    logic [6:0] r_flags;
    logic       ld;
    logic       r_valid;
    logic [7:0] r_out_byte;
    logic       r_last_byte;
    logic [6:0] r_chips_seen;

    assign o_valid      = r_valid;
    assign o_out_byte   = r_out_byte;
    assign o_last_byte  = r_last_byte;
    assign o_chips_seen = r_chips_seen;

    // output register is free to take a byte
    assign ld    = !r_valid || !i_stall;
    assign o_pop = i_nempty && ((r_cnt == 4'd0) || ((r_cnt == 4'd1) && ld));

    // Lay out the bytes of one command: wait, enable, body
    always_comb begin
        for (int k = 0; k < MAX_BYTES; k++) a_sh[k] = 8'd0;
        base = 4'd0;
        if (i_cmd.has_wait) begin
            a_sh[0] = OP_WAIT;
            a_sh[1] = i_cmd.wait_val[7:0];
            a_sh[2] = i_cmd.wait_val[15:8];
            base = 4'd3;
        end
        if (i_cmd.has_en) begin
            a_sh[base]        = OP_WAVE;
            a_sh[base + 4'd1] = WP_EN;
            a_sh[base + 4'd2] = WP_TABLE;
            a_sh[base + 4'd3] = WAVE_EN_DATA;
            base = base + 4'd4;
        end
        for (int j = 0; j < 4; j++) begin
            a_sh[base + 4'(j)] = i_cmd.body[j];
        end
        a_cnt = base + {1'b0, i_cmd.body_len};
    end

    // Byte counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (ld) r_valid <= (r_cnt != 4'd0);
            if (o_pop) begin
                r_cnt <= a_cnt;
            end else if (ld && (r_cnt != 4'd0)) begin
                r_cnt <= r_cnt - 4'd1;
            end
        end
    end

    // Shift register and output payload
    always_ff @(posedge i_clk) begin
        if (ld && (r_cnt != 4'd0)) begin
            r_out_byte   <= r_sh[0];
            r_last_byte  <= (r_cnt == 4'd1);
            r_chips_seen <= r_flags;
        end
        if (o_pop) begin
            r_sh    <= a_sh;
            r_flags <= i_cmd.flags;
        end else if (ld && (r_cnt != 4'd0)) begin
            for (int k = 0; k < MAX_BYTES - 1; k++) r_sh[k] <= r_sh[k + 1];
            r_sh[MAX_BYTES - 1] <= 8'd0;
        end
    end

endmodule

[rtl/sound_register_write_logger_top.sv]
// Sound register write logger. Takes I/O writes, memory writes, sample ticks and
// end markers, and streams out timed register-write commands byte by byte
// on the output channel, with o_last_byte on the final byte an input item causes.
// The front accepts one item per cycle while its two-entry command queue has room;
// items that only latch an address, tick the wait count without overflow, or miss
// every mapped port and window give no bytes. The back serializer sends one byte
// per cycle while the output is not stalled; an item yields 1 to 11 bytes (typically
// 3 or 4), and the next item's bytes follow without a gap when its command is queued.
module sound_register_write_logger_top
    import swl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic [6:0]  o_chips_seen
);

    logic push, pop, full, nempty;
    t_cmd f_cmd, q_cmd;

    assign o_stall = full;

    swl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_full  (full),
        .i_cmd   (i_cmd),
        .i_addr  (i_addr),
        .i_wdata (i_wdata),
        .o_push  (push),
        .o_cmd   (f_cmd)
    );

    swl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (f_cmd),
        .i_pop    (pop),
        .o_full   (full),
        .o_nempty (nempty),
        .o_cmd    (q_cmd)
    );

    swl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nempty     (nempty),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte),
        .o_chips_seen (o_chips_seen)
    );

endmodule

[rtl/swl_checker.sv]
`include "sound_register_write_logger_top_defines.svh"

module swl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_cmd,
    input logic [15:0] i_addr,
    input logic [7:0]  i_wdata,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_last_byte,
    input logic [6:0]  o_chips_seen
);

    // a stalled output byte holds
    `SWL_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last_byte) && $stable(o_chips_seen), "output changed under stall")

    // bytes of one item follow back to back with the same chip flags
    `SWL_ASSERT(a_item_burst, o_valid && !i_stall && !o_last_byte |=> o_valid && (o_chips_seen == $past(o_chips_seen)), "gap or flag change inside an item")

    // reset empties both sides
    `SWL_ASSERT_RST(a_reset, !i_rst_n |=> !o_valid && !o_stall, "not idle after reset")

endmodule

bind sound_register_write_logger_top swl_checker u_swl_checker (.*);

[tb/sv/sound_register_write_logger_top_test.sv]
`timescale 1ns / 100ps

module sound_register_write_logger_top_test;
    import swl_pkg::*;

    // One byte of the command stream as the block should give it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic [6:0] chips_seen;
    } t_stream_byte;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    // Tracks chip state and the bytes still owed by the block
    class stream_scoreboard;
        logic [15:0]  wait_count;
        logic [7:0]   fm_reg;
        logic [7:0]   opl_reg;
        logic [7:0]   psg_reg;
        bit           wave_enabled;
        logic [6:0]   chip_flags;
        logic [7:0]   item_bytes[$];
        t_stream_byte expected_bytes[$];
        int           errors;

        function new();
            wait_count   = '0;
            fm_reg       = '0;
            opl_reg      = '0;
            psg_reg      = '0;
            wave_enabled = 1'b0;
            chip_flags   = '0;
            errors       = 0;
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction

        // Any pending wait goes out ahead of a command
        function void flush_wait();
            if (wait_count != '0) begin
                item_bytes.push_back(OP_WAIT);
                item_bytes.push_back(wait_count[7:0]);
                item_bytes.push_back(wait_count[15:8]);
                wait_count = '0;
            end
        endfunction

        function void put_cmd(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2,
                              input bit three);
            flush_wait();
            item_bytes.push_back(op);
            item_bytes.push_back(b1);
            if (three)
                item_bytes.push_back(b2);
        endfunction

        // Wave command, with the enable command ahead of the first one
        function void put_wave(input logic [7:0] port, input logic [7:0] off,
                               input logic [7:0] data);
            if (!wave_enabled) begin
                flush_wait();
                item_bytes.push_back(OP_WAVE);
                item_bytes.push_back(WP_EN);
                item_bytes.push_back(8'h00);
                item_bytes.push_back(WAVE_EN_DATA);
                wave_enabled = 1'b1;
            end
            flush_wait();
            item_bytes.push_back(OP_WAVE);
            item_bytes.push_back(port);
            item_bytes.push_back(off);
            item_bytes.push_back(data);
        endfunction

        function void io_write(input logic [15:0] port, input logic [7:0] data);
            if (port == IO_FM_ADR0 || port == IO_FM_ADR1) begin
                chip_flags[F_FM] = 1'b1;
                fm_reg = data;
            end else if (port == IO_FM_DAT0 || port == IO_FM_DAT1) begin
                put_cmd(OP_FM, fm_reg, data, 1'b1);
            end else if (port == IO_OPL_ADR) begin
                chip_flags[F_OPL] = 1'b1;
                opl_reg = data;
                if (data == OPL_ADPCM_REG)
                    chip_flags[F_ADPCM] = 1'b1;
            end else if (port == IO_OPL_DAT) begin
                put_cmd(OP_OPL, opl_reg, data, 1'b1);
            end else if (port == IO_PSG_ADR) begin
                chip_flags[F_PSG] = 1'b1;
                psg_reg = data;
            end else if (port == IO_PSG_DAT) begin
                put_cmd(OP_PSG, psg_reg, data, 1'b1);
            end else if (port == IO_TONE0 || port == IO_TONE1) begin
                chip_flags[F_TONE] = 1'b1;
                put_cmd(OP_TONE, data, 8'h00, 1'b0);
            end else if (port == IO_STEREO) begin
                put_cmd(OP_STEREO, data, 8'h00, 1'b0);
            end
        endfunction

        // First window: 0x90-0x9F mirrors the frequency/volume/enable block
        function void wave_write(input logic [7:0] lo, input logic [7:0] data);
            bit         hit;
            logic [7:0] port;
            logic [7:0] off;
            hit  = 1'b1;
            port = WP_TABLE;
            off  = lo;
            if (lo <= 8'h7F) begin
                port = WP_TABLE;
            end else if (lo <= 8'h89) begin
                port = WP_FREQ;
                off  = lo - 8'h80;
                if (data != '0) chip_flags[F_WAVE] = 1'b1;
            end else if (lo <= 8'h8E) begin
                port = WP_VOL;
                off  = lo - 8'h8A;
            end else if (lo == 8'h8F) begin
                port = WP_EN;
                off  = 8'h00;
            end else if (lo <= 8'h99) begin
                port = WP_FREQ;
                off  = lo - 8'h90;
                if (data != '0) chip_flags[F_WAVE] = 1'b1;
            end else if (lo <= 8'h9E) begin
                port = WP_VOL;
                off  = lo - 8'h9A;
            end else if (lo == 8'h9F) begin
                port = WP_EN;
                off  = 8'h00;
            end else if (lo <= 8'hDF) begin
                hit = 1'b0;
            end else begin
                port = WP_SHARE;
                off  = lo - 8'hE0;
            end
            if (hit)
                put_wave(port, off, data);
        endfunction

        // Second window: 0xB0-0xBF mirrors 0xA0-0xAF
        function void wplus_write(input logic [7:0] lo, input logic [7:0] data);
            bit         hit;
            logic [7:0] port;
            logic [7:0] off;
            hit  = 1'b1;
            port = WP_TABLE;
            off  = lo;
            if (lo <= 8'h7F) begin
                port = WP_TABLE;
            end else if (lo <= 8'h9F) begin
                port = WP_PTAB;
            end else if (lo <= 8'hA9) begin
                port = WP_FREQ;
                off  = lo - 8'hA0;
                if (data != '0) chip_flags[F_WPLUS] = 1'b1;
            end else if (lo <= 8'hAE) begin
                port = WP_VOL;
                off  = lo - 8'hAA;
            end else if (lo == 8'hAF) begin
                port = WP_EN;
                off  = 8'h00;
            end else if (lo <= 8'hB9) begin
                port = WP_FREQ;
                off  = lo - 8'hB0;
                if (data != '0) chip_flags[F_WPLUS] = 1'b1;
            end else if (lo <= 8'hBE) begin
                port = WP_VOL;
                off  = lo - 8'hBA;
            end else if (lo == 8'hBF) begin
                port = WP_EN;
                off  = 8'h00;
            end else if (lo <= 8'hDF) begin
                port = WP_SHARE;
                off  = lo - 8'hC0;
            end else begin
                hit = 1'b0;
            end
            if (hit)
                put_wave(port, off, data);
        endfunction

        // Called for each accepted input item
        function void note_item(input logic [1:0] cmd, input logic [15:0] addr,
                                input logic [7:0] data);
            t_stream_byte sb_entry;
            item_bytes.delete();
            case (cmd)
                CMD_IO: begin
                    io_write(addr, data);
                end
                CMD_MEM: begin
                    if (addr[15:8] == WAVE_BASE)
                        wave_write(addr[7:0], data);
                    else if (addr[15:8] == WPLUS_BASE)
                        wplus_write(addr[7:0], data);
                end
                CMD_TICK: begin
                    // Wait count saturates: flush a full wait, keep this tick
                    if (wait_count == WAIT_MAX) begin
                        item_bytes.push_back(OP_WAIT);
                        item_bytes.push_back(8'hFF);
                        item_bytes.push_back(8'hFF);
                        wait_count = 16'd1;
                    end else begin
                        wait_count = wait_count + 16'd1;
                    end
                end
                default: begin
                    flush_wait();
                    item_bytes.push_back(OP_END);
                end
            endcase
            for (int k = 0; k < item_bytes.size() && k < MAX_BYTES; k++) begin
                sb_entry.out_byte   = item_bytes[k];
                sb_entry.last_byte  = (k == item_bytes.size() - 1);
                sb_entry.chips_seen = chip_flags;
                expected_bytes.push_back(sb_entry);
            end
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // Called for each accepted output byte
        task check_byte(input logic [7:0] out_byte, input logic last_byte,
                        input logic [6:0] chips_seen);
            t_stream_byte want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last=%0b chips=%02h",
                                          out_byte, last_byte, chips_seen));
            end else begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.out_byte || last_byte !== want.last_byte ||
                    chips_seen !== want.chips_seen)
                    report_mismatch($sformatf(
                        "got byte %02h last=%0b chips=%02h, want %02h last=%0b chips=%02h",
                        out_byte, last_byte, chips_seen,
                        want.out_byte, want.last_byte, want.chips_seen));
            end
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [1:0]  i_cmd      = CMD_IO;
    logic [15:0] i_addr     = '0;
    logic [7:0]  i_wdata    = '0;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic [6:0]  o_chips_seen;

    stream_scoreboard sb = new();
    int idle_cycles = 0;
    int stall_left  = 0;
    bit src_quiet   = 1'b0;
    bit sink_quiet  = 1'b0;

    sound_register_write_logger_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_addr      (i_addr),
        .i_wdata     (i_wdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_chips_seen(o_chips_seen)
    );

    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Handshake monitor: note inputs first, then check outputs
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_item(i_cmd, i_addr, i_wdata);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_byte(o_out_byte, o_last_byte, o_chips_seen);
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        if (sink_quiet || stall_left == 0) begin
            i_stall <= 1'b0;
            if (!sink_quiet && $urandom_range(0, 3) == 0)
                stall_left <= gap_len();
        end else begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // Watchdog
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Present one item and hold it until it is taken
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [7:0] data);
        int gap;
        gap = src_quiet ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_addr  <= addr;
        i_wdata <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Sender holds off until the stream has caught up
    task automatic drain_pause();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_item(CMD_TICK, 16'h0000, 8'h00);
        send_item(CMD_IO, IO_FM_ADR0, 8'hFF);
        send_item(CMD_IO, IO_FM_DAT0, 8'h00);
        send_item(CMD_IO, IO_FM_ADR1, 8'h12);
        send_item(CMD_IO, IO_FM_DAT1, 8'hFF);
        send_item(CMD_IO, IO_OPL_ADR, OPL_ADPCM_REG);
        send_item(CMD_IO, IO_OPL_DAT, 8'hA5);
        send_item(CMD_IO, IO_PSG_ADR, 8'h07);
        send_item(CMD_IO, IO_PSG_DAT, 8'h3C);
        send_item(CMD_IO, IO_TONE0, 8'h80);
        send_item(CMD_IO, IO_TONE1, 8'h01);
        send_item(CMD_IO, IO_STEREO, 8'hFF);
        send_item(CMD_IO, 16'hFFFF, 8'hAA);
        // first wave write brings the enable command with it
        send_item(CMD_MEM, 16'h9800, 8'h55);
        send_item(CMD_MEM, 16'h9889, 8'h00);
        send_item(CMD_MEM, 16'h9890, 8'h01);
        send_item(CMD_MEM, 16'h988A, 8'h0F);
        send_item(CMD_MEM, 16'h989F, 8'h1F);
        send_item(CMD_MEM, 16'h98C0, 8'h33);
        send_item(CMD_MEM, 16'h98FF, 8'hC3);
        send_item(CMD_MEM, 16'hB89F, 8'h44);
        send_item(CMD_MEM, 16'hB8B9, 8'h7F);
        send_item(CMD_MEM, 16'hB8AF, 8'h03);
        send_item(CMD_MEM, 16'hB8DF, 8'h99);
        send_item(CMD_MEM, 16'hB8E0, 8'h99);
        send_item(CMD_MEM, 16'h0000, 8'hFF);
        send_item(CMD_END, 16'hFFFF, 8'hFF);
    endtask

    task automatic run_random(input int n_items);
        int          done_items;
        int          pick;
        int          burst;
        logic [15:0] a;
        logic [7:0]  d;
        done_items = 0;
        while (done_items < n_items) begin
            // a stretch with no random gaps or stalls on either side
            src_quiet  = (done_items >= 80 && done_items < 120);
            sink_quiet = src_quiet;
            if ($urandom_range(0, 39) == 0)
                drain_pause();
            pick = $urandom_range(0, 99);
            d    = 8'($urandom);
            if (pick < 40) begin
                case ($urandom_range(0, 10))
                    0:       a = IO_FM_ADR0;
                    1:       a = IO_FM_ADR1;
                    2:       a = IO_FM_DAT0;
                    3:       a = IO_FM_DAT1;
                    4:       a = IO_OPL_ADR;
                    5:       a = IO_OPL_DAT;
                    6:       a = IO_PSG_ADR;
                    7:       a = IO_PSG_DAT;
                    8:       a = IO_TONE0;
                    9:       a = IO_TONE1;
                    default: a = IO_STEREO;
                endcase
                if (a == IO_OPL_ADR && $urandom_range(0, 3) == 0)
                    d = OPL_ADPCM_REG;
                send_item(CMD_IO, a, d);
                done_items++;
            end else if (pick < 70) begin
                a = {($urandom_range(0, 1) != 0) ? WAVE_BASE : WPLUS_BASE, 8'($urandom)};
                if ($urandom_range(0, 3) == 0)
                    d = 8'h00;
                send_item(CMD_MEM, a, d);
                done_items++;
            end else if (pick < 85) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 10) : 1;
                repeat (burst) send_item(CMD_TICK, 16'($urandom), 8'($urandom));
                done_items++;
            end else if (pick < 90) begin
                send_item(CMD_END, 16'($urandom), d);
                done_items++;
            end else begin
                // noise: any kind, any address
                send_item(2'($urandom), 16'($urandom), d);
                done_items++;
            end
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    // Main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain_pause();
        run_random(200);
        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/swl_pkg.sv
rtl/swl_front.sv
rtl/swl_queue.sv
rtl/swl_back.sv
rtl/sound_register_write_logger_top.sv
rtl/swl_checker.sv
tb/sv/sound_register_write_logger_top_test.sv
